FILE: src/ddo_pkg.sv
package ddo_pkg;

    localparam int DIAM_W      = 16;
    localparam int SPEED_W     = 24;
    localparam int DT_W        = 16;
    localparam int POS_W       = 32;
    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 96;

    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic [15:0] DIAM_RST    = 16'd1024;
    localparam logic [15:0] SPACING_RST = 16'd2560;

    localparam logic [0:0] REG_DIAMETER = 1'b0;
    localparam logic [0:0] REG_SPACING  = 1'b1;

    localparam logic [0:0] OP_ADVANCE = 1'b0;
    localparam logic [0:0] OP_LOAD    = 1'b1;

    localparam logic [11:0] DIST_DIV   = 12'd2000;
    localparam logic [9:0]  SPACE_MULT = 10'd1000;
    localparam logic [17:0] PI_Q16     = 18'd205887;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2F9;
            5'd15:   v = 32'h0000517C;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A2F;
            5'd19:   v = 32'h00000517;
            5'd20:   v = 32'h0000028B;
            5'd21:   v = 32'h00000145;
            5'd22:   v = 32'h000000A2;
            5'd23:   v = 32'h00000051;
            5'd24:   v = 32'h00000028;
            5'd25:   v = 32'h00000014;
            5'd26:   v = 32'h0000000A;
            5'd27:   v = 32'h00000005;
            5'd28:   v = 32'h00000002;
            5'd29:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: src/differential_drive_odometry.sv
// A load item goes from the idle state to the done state and then into the
// output register; an advance item runs bit-serial multiplies, a 72-step
// restoring divide and one CORDIC iteration per cycle, all through one sequencer.
// Throughput: one item at a time; the next item is taken once the result is in
// the output register. Reset zeroes the pose and loads default wheel geometry.
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // left_speed, right_speed, elapsed_ms, set_x, set_y, set_heading
    input  logic [IN_DATA_W-1:0]    s_tdata,
    // operation
    input  logic                    s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pose_x, pose_y, pose_heading
    output logic [OUT_DATA_W-1:0]   m_tdata,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [DIAM_W-1:0]       cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_MUL3  = 4'd4;
    localparam logic [3:0] S_CORD  = 4'd5;
    localparam logic [3:0] S_TRIG  = 4'd6;
    localparam logic [3:0] S_SCALE = 4'd7;
    localparam logic [3:0] S_UPD   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam int MUL1_LEN  = 16;
    localparam int MUL2_LEN  = 25;
    localparam int DIV_LEN   = 72;
    localparam int MUL3_LEN  = 18;
    localparam int SCALE_LEN = 33;

    logic [3:0]  state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [15:0] wd_reg, ws_reg;
    logic [31:0] px_reg, px_next, py_reg, py_next, ph_reg, ph_next;
    logic [15:0] dt_reg, dt_next;
    logic [31:0] a_reg, a_next;
    logic [24:0] smag_reg, smag_next, dfmag_reg, dfmag_next;
    logic        sneg_reg, sneg_next, dneg_reg, dneg_next;
    logic [25:0] den_reg, den_next;
    logic [71:0] p_reg, p_next, m_reg, m_next;
    logic [10:0] remp_reg, remp_next;
    logic [25:0] remm_reg, remm_next;
    logic [60:0] qp_reg, qp_next;
    logic [31:0] qm_reg, qm_next;
    logic [63:0] dacc_reg, dacc_next;
    logic signed [33:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [32:0] cz_reg, cz_next;
    logic [1:0]  quad_reg, quad_next;
    logic [32:0] tms_reg, tms_next, tmc_reg, tmc_next;
    logic        negx_reg, negx_next, negy_reg, negy_next;
    logic [61:0] sx_reg, sx_next, sy_reg, sy_next;
    logic        outv_reg, outv_next;
    logic [95:0] out_reg, out_next;

    logic signed [24:0] lsp, rsp, sum, diff;
    logic [11:0] remp_sh;
    logic [26:0] remm_sh;
    logic        gep, gem;
    logic [39:0] dmag;
    logic signed [33:0] xs, ys, sn, cs;
    logic [31:0] t_ang, rx, ry;
    logic        accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = outv_reg;
    assign m_tdata  = out_reg;

    assign lsp  = 25'(signed'(s_tdata[23:0]));
    assign rsp  = 25'(signed'(s_tdata[47:24]));
    assign sum  = lsp + rsp;
    assign diff = lsp - rsp;

    assign remp_sh = {remp_reg, p_reg[71]};
    assign remm_sh = {remm_reg, m_reg[71]};
    assign gep     = remp_sh >= DIST_DIV;
    assign gem     = remm_sh >= {1'b0, den_reg};
    assign dmag    = dacc_reg[63:24];
    assign xs      = cx_reg >>> cnt_reg[4:0];
    assign ys      = cy_reg >>> cnt_reg[4:0];
    assign t_ang   = ph_reg + 32'h2000_0000;
    assign rx      = sx_reg[61:30];
    assign ry      = sy_reg[61:30];

    always_comb
    begin
        unique case (quad_reg)
            2'd0:
            begin
                sn = cy_reg;
                cs = cx_reg;
            end
            2'd1:
            begin
                sn = cx_reg;
                cs = -cy_reg;
            end
            2'd2:
            begin
                sn = -cy_reg;
                cs = -cx_reg;
            end
            default:
            begin
                sn = -cx_reg;
                cs = cy_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 7'd1;
        px_next    = px_reg;
        py_next    = py_reg;
        ph_next    = ph_reg;
        dt_next    = dt_reg;
        a_next     = a_reg;
        smag_next  = smag_reg;
        dfmag_next = dfmag_reg;
        sneg_next  = sneg_reg;
        dneg_next  = dneg_reg;
        den_next   = den_reg;
        p_next     = p_reg;
        m_next     = m_reg;
        remp_next  = remp_reg;
        remm_next  = remm_reg;
        qp_next    = qp_reg;
        qm_next    = qm_reg;
        dacc_next  = dacc_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        quad_next  = quad_reg;
        tms_next   = tms_reg;
        tmc_next   = tmc_reg;
        negx_next  = negx_reg;
        negy_next  = negy_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        outv_next  = outv_reg && !m_tready;
        out_next   = out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    if (s_tuser == OP_LOAD)
                    begin
                        px_next    = s_tdata[95:64];
                        py_next    = s_tdata[127:96];
                        ph_next    = s_tdata[159:128];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        dt_next    = s_tdata[63:48];
                        sneg_next  = sum[24];
                        dneg_next  = diff[24];
                        smag_next  = sum[24] ? 25'(-sum) : 25'(sum);
                        dfmag_next = diff[24] ? 25'(-diff) : 25'(diff);
                        den_next   = 26'(ws_reg * SPACE_MULT);
                        a_next     = '0;
                        p_next     = '0;
                        m_next     = '0;
                        remp_next  = '0;
                        remm_next  = '0;
                        qp_next    = '0;
                        qm_next    = '0;
                        dacc_next  = '0;
                        sx_next    = '0;
                        sy_next    = '0;
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                a_next  = {a_reg[30:0], 1'b0} + (dt_reg[15] ? {16'b0, wd_reg} : 32'b0);
                dt_next = {dt_reg[14:0], 1'b0};
                if (cnt_reg == 7'(MUL1_LEN - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                p_next = {p_reg[70:0], 1'b0}
                       + (smag_reg[24] ? {25'b0, a_reg, 15'b0} : 72'b0);
                m_next = {m_reg[70:0], 1'b0}
                       + (dfmag_reg[24] ? {25'b0, a_reg, 15'b0} : 72'b0);
                smag_next  = {smag_reg[23:0], 1'b0};
                dfmag_next = {dfmag_reg[23:0], 1'b0};
                if (cnt_reg == 7'(MUL2_LEN - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                remp_next = gep ? 11'(remp_sh - DIST_DIV) : remp_sh[10:0];
                remm_next = gem ? 26'(remm_sh - {1'b0, den_reg}) : remm_sh[25:0];
                qp_next   = {qp_reg[59:0], gep};
                qm_next   = {qm_reg[30:0], gem};
                p_next    = {p_reg[70:0], 1'b0};
                m_next    = {m_reg[70:0], 1'b0};
                if (cnt_reg == 7'(DIV_LEN - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_MUL3;
                end
            end
            S_MUL3:
            begin
                dacc_next = {dacc_reg[62:0], 1'b0}
                          + (PI_Q16[5'(7'(MUL3_LEN - 1) - cnt_reg)]
                             ? {18'b0, qp_reg[60:15]} : 64'b0);
                if (cnt_reg == 7'(MUL3_LEN - 1))
                begin
                    cnt_next   = '0;
                    cx_next    = CORDIC_GAIN;
                    cy_next    = '0;
                    cz_next    = {3'b0, t_ang[29:0]} - 33'sh2000_0000;
                    quad_next  = t_ang[31:30];
                    state_next = S_CORD;
                end
            end
            S_CORD:
            begin
                if (!cz_reg[32])
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - signed'({1'b0, atan_bam(cnt_reg[4:0])});
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + signed'({1'b0, atan_bam(cnt_reg[4:0])});
                end
                if (cnt_reg == 7'(CORDIC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_TRIG;
                end
            end
            S_TRIG:
            begin
                tms_next   = sn[33] ? 33'(-sn) : 33'(sn);
                tmc_next   = cs[33] ? 33'(-cs) : 33'(cs);
                negx_next  = sneg_reg ^ sn[33];
                negy_next  = sneg_reg ^ cs[33];
                cnt_next   = '0;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                sx_next  = {sx_reg[60:0], 1'b0} + (tms_reg[32] ? {22'b0, dmag} : 62'b0);
                sy_next  = {sy_reg[60:0], 1'b0} + (tmc_reg[32] ? {22'b0, dmag} : 62'b0);
                tms_next = {tms_reg[31:0], 1'b0};
                tmc_next = {tmc_reg[31:0], 1'b0};
                if (cnt_reg == 7'(SCALE_LEN - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                px_next = px_reg + (negx_reg ? 32'(-rx) : rx);
                py_next = py_reg + (negy_reg ? 32'(-ry) : ry);
                if (ws_reg != 16'd0)
                begin
                    ph_next = dneg_reg ? ph_reg - qm_reg : ph_reg + qm_reg;
                end
                cnt_next   = '0;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cnt_next = '0;
                if (!outv_reg || m_tready)
                begin
                    outv_next  = 1'b1;
                    out_next   = {ph_reg, py_reg, px_reg};
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                cnt_next   = '0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            wd_reg    <= DIAM_RST;
            ws_reg    <= SPACING_RST;
            px_reg    <= '0;
            py_reg    <= '0;
            ph_reg    <= '0;
            outv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            ph_reg    <= ph_next;
            outv_reg  <= outv_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DIAMETER: wd_reg <= cfg_data;
                    REG_SPACING:  ws_reg <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg    <= dt_next;
        a_reg     <= a_next;
        smag_reg  <= smag_next;
        dfmag_reg <= dfmag_next;
        sneg_reg  <= sneg_next;
        dneg_reg  <= dneg_next;
        den_reg   <= den_next;
        p_reg     <= p_next;
        m_reg     <= m_next;
        remp_reg  <= remp_next;
        remm_reg  <= remm_next;
        qp_reg    <= qp_next;
        qm_reg    <= qm_next;
        dacc_reg  <= dacc_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        quad_reg  <= quad_next;
        tms_reg   <= tms_next;
        tmc_reg   <= tmc_next;
        negx_reg  <= negx_next;
        negy_reg  <= negy_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        out_reg   <= out_next;
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("sequencer idle after accepting an item");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result shown without finishing an item");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < 7'(DIV_LEN))
        else $error("step counter out of range");

    a_pose_stable_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && !accept |=> $stable(px_reg) && $stable(ph_reg))
        else $error("pose changed while idle");
`endif

endmodule

FILE: sim/testbench.sv
module testbench;
    import ddo_pkg::*;

    localparam int CORDIC_N    = CORDIC_STEPS_DEF;
    localparam int ADV_LAT     = 170 + CORDIC_N;
    localparam int RANDOM_N    = 900;
    localparam longint MAX_CYC = 3000000;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we;
    logic [0:0]             cfg_index;
    logic [DIAM_W-1:0]      cfg_data;

    typedef struct packed {
        logic [31:0] heading;
        logic [31:0] y;
        logic [31:0] x;
    } pose_t;

    typedef struct {
        logic [0:0]  op;
        logic [23:0] left;
        logic [23:0] right;
        logic [15:0] dt;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sh;
        bit          has_pose;
        pose_t       pose;
    } row_t;

    pose_t       pose_queue[$];
    pose_t       cur_pose;
    logic [15:0] diameter;
    logic [15:0] spacing;
    int          mismatches;
    longint      cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          hold_cycles;

    differential_drive_odometry u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic longint atan_step(int i);
        longint t[16];
        t = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
              64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
              64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
              64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C};
        return (i < 16) ? t[i] : 64'd0;
    endfunction

    task automatic heading_trig(input logic [31:0] h, output longint sn, output longint cs);
        logic [31:0] t;
        longint      z;
        longint      vx;
        longint      vy;
        longint      xs;
        longint      ys;
        t  = h + 32'h20000000;
        z  = longint'(t[29:0]) - 64'sh20000000;
        vx = 652032874;
        vy = 0;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (z >= 0)
            begin
                vx -= ys; vy += xs; z -= atan_step(i);
            end
            else
            begin
                vx += ys; vy -= xs; z += atan_step(i);
            end
        end
        case (t[31:30])
            2'd0: begin sn = vy;  cs = vx;  end
            2'd1: begin sn = vx;  cs = -vy; end
            2'd2: begin sn = -vy; cs = -vx; end
            default: begin sn = -vx; cs = vy; end
        endcase
    endtask

    function automatic logic [31:0] scaled_step(logic [63:0] dmag, bit dneg, longint trig);
        logic [127:0] prod;
        logic [31:0]  r;
        bit           neg;
        neg  = dneg ^ (trig < 0);
        prod = dmag * 128'(trig < 0 ? -trig : trig);
        r    = prod[61:30];
        return neg ? -r : r;
    endfunction

    task automatic apply_item(input row_t it);
        longint       l, r, sum, diff, sn, cs;
        logic [63:0]  smag, dfmag, dmag, m, den, q1, r1;
        logic [31:0]  dh;
        if (it.op == OP_LOAD)
        begin
            cur_pose.x = it.sx; cur_pose.y = it.sy; cur_pose.heading = it.sh;
            return;
        end
        l     = longint'($signed(it.left));
        r     = longint'($signed(it.right));
        sum   = l + r;
        diff  = l - r;
        smag  = sum < 0 ? -sum : sum;
        dfmag = diff < 0 ? -diff : diff;
        dmag  = (((64'(it.dt) * diameter * smag) / 2000) * 205887) >> 24;
        heading_trig(cur_pose.heading, sn, cs);
        cur_pose.x += scaled_step(dmag, sum < 0, sn);
        cur_pose.y += scaled_step(dmag, sum < 0, cs);
        if (spacing != 0)
        begin
            den = 64'(spacing) * 1000;
            m   = 64'(it.dt) * diameter * dfmag;
            q1  = m / den;
            r1  = m % den;
            dh  = 32'((q1 << 15) + (r1 << 15) / den);
            if (diff < 0)
                cur_pose.heading -= dh;
            else
                cur_pose.heading += dh;
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_DIAMETER)
            diameter = val;
        else
            spacing = val;
    endtask

    task automatic send_item(input row_t it);
        pose_t exp_pose;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        apply_item(it);
        exp_pose = it.has_pose ? it.pose : cur_pose;
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {it.sh, it.sy, it.sx, it.dt, it.right, it.left};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pose_queue.push_back(exp_pose);
        @(negedge clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pose_queue.size() != 0)
            @(negedge clk);
        repeat (ADV_LAT + 10) @(negedge clk);
    endtask

    function automatic row_t random_item();
        row_t it;
        int   k;
        it          = '{default: '0};
        it.op       = ($urandom_range(9) == 0) ? OP_LOAD : OP_ADVANCE;
        it.left     = 24'($urandom);
        it.right    = 24'($urandom);
        it.sx       = $urandom;
        it.sy       = $urandom;
        it.sh       = $urandom;
        k           = $urandom_range(3);
        it.dt       = (k == 0) ? 16'($urandom) : 16'($urandom_range(50));
        if ($urandom_range(1))
        begin
            it.left  = 24'($signed(24'($urandom_range(65536 * 4))) - 24'sd131072);
            it.right = 24'($signed(24'($urandom_range(65536 * 4))) - 24'sd131072);
        end
        return it;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("Mismatches found");
            $finish;
        end
        if (m_tvalid && m_tready)
        begin
            if (pose_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item %h", m_tdata);
            end
            else
            begin
                if (m_tdata !== pose_queue[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pose mismatch: exp x=%h y=%h h=%h got x=%h y=%h h=%h",
                                 pose_queue[0].x, pose_queue[0].y, pose_queue[0].heading,
                                 m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]);
                end
                void'(pose_queue.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off)
        begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles + 1;
            if (hold_cycles >= 2000)
                hold_off <= 1'b0;
        end
        else
            m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        row_t dir[$];
        row_t it;
        int   phase;
        rst_n = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        m_tready = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        mismatches = 0; cycles = 0; send_idle_pct = 0; recv_stall_pct = 0;
        hold_off = 1'b0; hold_cycles = 0;
        diameter = DIAM_RST; spacing = SPACING_RST; cur_pose = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // op, left, right, dt, set x/y/h, has_pose, pose
        dir.push_back('{OP_ADVANCE, 24'd0, 24'd0, 16'd0, 32'd0, 32'd0, 32'd0, 1, '0});
        dir.push_back('{OP_ADVANCE, 24'h010000, 24'h010000, 16'd0, '0, '0, '0, 1, '0});
        dir.push_back('{OP_ADVANCE, 24'h010000, 24'h010000, 16'd100, '0, '0, '0, 0, '0});
        dir.push_back('{OP_ADVANCE, 24'h7FFFFF, 24'h800000, 16'd65535, '0, '0, '0, 0, '0});
        dir.push_back('{OP_ADVANCE, 24'h800000, 24'h7FFFFF, 16'd65535, '0, '0, '0, 0, '0});
        dir.push_back('{OP_ADVANCE, 24'h7FFFFF, 24'h7FFFFF, 16'd65535, '0, '0, '0, 0, '0});
        dir.push_back('{OP_ADVANCE, 24'h800000, 24'h800000, 16'd65535, '0, '0, '0, 0, '0});
        dir.push_back('{OP_LOAD, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 32'h7FFFFFFF,
                        32'h80000000, 32'hFFFFFFFF, 1,
                        '{heading: 32'hFFFFFFFF, y: 32'h80000000, x: 32'h7FFFFFFF}});
        dir.push_back('{OP_ADVANCE, 24'h7FFFFF, 24'h7FFFFF, 16'd65535, '1, '1, '1, 0, '0});
        for (int q = 0; q < 4; q++)
        begin
            dir.push_back('{OP_LOAD, '0, '0, '0, 32'd0, 32'd0, 32'(q) << 30, 0, '0});
            dir.push_back('{OP_ADVANCE, 24'h020000, 24'h010000, 16'd500, '0, '0, '0, 0, '0});
            dir.push_back('{OP_ADVANCE, 24'hFF0000, 24'hFE0000, 16'd500, '0, '0, '0, 0, '0});
        end
        dir.push_back('{OP_LOAD, '0, '0, '0, '0, '0, '0, 1, '0});
        foreach (dir[i])
            send_item(dir[i]);
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(REG_DIAMETER, 16'd1);     write_reg(REG_SPACING, 16'd1); end
                1: begin write_reg(REG_DIAMETER, 16'hFFFF);  write_reg(REG_SPACING, 16'hFFFF); end
                2: begin write_reg(REG_DIAMETER, 16'd0);     write_reg(REG_SPACING, 16'd0); end
                3: begin write_reg(REG_DIAMETER, 16'($urandom)); write_reg(REG_SPACING, 16'd0); end
                default:
                begin
                    write_reg(REG_DIAMETER, 16'($urandom_range(1, 65535)));
                    write_reg(REG_SPACING, 16'($urandom_range(1, 65535)));
                end
            endcase
            send_idle_pct  = (phase == 1 || phase == 5) ? 67 : (phase == 3 ? 27 : 0);
            recv_stall_pct = (phase == 2 || phase == 5) ? 67 : (phase == 3 ? 27 : 0);
            if (phase == 4)
            begin
                hold_cycles = 0;
                hold_off = 1'b1;
            end
            for (int n = 0; n < RANDOM_N / 6; n++)
            begin
                it = random_item();
                send_item(it);
                if (n == 70)
                begin
                    s_tvalid <= 1'b0;
                    @(negedge clk);
                    while (pose_queue.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
src/ddo_pkg.sv
src/differential_drive_odometry.sv
sim/testbench.sv
